>>> rtl/pbfc_pkg.sv
// Package for the portal box frustum classifier.
// Holds shared result codes, widths and the stage payload types; no dependencies.
package pbfc_pkg;

  localparam int unsigned NormBits = 16;

  typedef enum logic [1:0] {
    ActFull    = 2'd0,
    ActReject  = 2'd1,
    ActProject = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CfgCamX       = 2'd0,
    CfgCamY       = 2'd1,
    CfgCamZ       = 2'd2,
    CfgPlaneCount = 2'd3
  } cfg_idx_e;

  localparam logic CmdLoad     = 1'b0;
  localparam logic CmdClassify = 1'b1;

  typedef struct packed {
    logic    decided;
    action_e action;
    logic    range_error;
  } verdict_t;

endpackage

>>> rtl/pbfc_plane_dot.sv
// One plane test as a three-stage pipeline: corner select and products, partial sums, compare.
// Depends on pbfc_pkg for NormBits.
module pbfc_plane_dot #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic signed [COORD_BITS-1:0]         lo_i [3],
  input  logic signed [COORD_BITS-1:0]         hi_i [3],
  input  logic signed [pbfc_pkg::NormBits-1:0] normal_i [3],
  input  logic signed [COORD_BITS-1:0]         offset_i,
  output logic                                 reject_o
);
  localparam int unsigned ProdBits = COORD_BITS + pbfc_pkg::NormBits;
  localparam int unsigned SumBits  = ProdBits + 3;

  logic signed [ProdBits-1:0] prod_d [3];
  logic signed [ProdBits-1:0] prod_q [3];
  logic signed [ProdBits-1:0] offs_q;
  logic signed [SumBits-1:0]  sum_d, sum_q;
  logic                       reject_d, reject_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_d[j] = ProdBits'((normal_i[j] > 0) ? lo_i[j] : hi_i[j]) * ProdBits'(normal_i[j]);
    end
    sum_d = SumBits'(prod_q[0]) + SumBits'(prod_q[1]) + SumBits'(prod_q[2])
          + SumBits'(offs_q);
    reject_d = (sum_q > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 1'b0;
    end else if (en_i) begin
      prod_q   <= prod_d;
      offs_q   <= ProdBits'(offset_i) <<< pbfc_pkg::NormBits - 2;
      sum_q    <= sum_d;
      reject_q <= reject_d;
    end
  end

  assign reject_o = reject_q;
endmodule

>>> rtl/pbfc_box_check.sv
// Stage-one box checks: inverted range and camera inside the grown box.
// Depends on pbfc_pkg for the verdict type and action codes.
module pbfc_box_check #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] lo_i [3],
  input  logic signed [COORD_BITS-1:0] hi_i [3],
  input  logic signed [COORD_BITS-1:0] cam_i [3],
  output pbfc_pkg::verdict_t           verdict_o
);
  logic inv, cam_in;

  always_comb begin
    inv    = 1'b0;
    cam_in = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if (lo_i[j] > hi_i[j]) inv = 1'b1;
      if ((COORD_BITS+1)'(cam_i[j]) < (COORD_BITS+1)'(lo_i[j]) - (COORD_BITS+1)'(256) ||
          (COORD_BITS+1)'(cam_i[j]) > (COORD_BITS+1)'(hi_i[j]) + (COORD_BITS+1)'(256))
        cam_in = 1'b0;
    end
    verdict_o.decided     = inv | cam_in;
    verdict_o.action      = pbfc_pkg::ActFull;
    verdict_o.range_error = inv;
  end
endmodule

>>> rtl/portal_box_frustum_classify.sv
// Portal box frustum classifier top level: plane store, box checks, parallel plane pipelines.
// A classify request gives one result; one request per cycle while the output is not stalled.
// Planes are tested in parallel three-stage lanes that follow a registered copy of the box.
// Load requests give no result. Reset clears control state and configuration to zero;
// plane entries are undefined until written.
module portal_box_frustum_classify #(
  parameter int unsigned MAX_PLANES = 6,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [COORD_BITS-1:0]                cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [2:0]                           plane_slot_i,
  input  logic signed [pbfc_pkg::NormBits-1:0] normal_x_i,
  input  logic signed [pbfc_pkg::NormBits-1:0] normal_y_i,
  input  logic signed [pbfc_pkg::NormBits-1:0] normal_z_i,
  input  logic signed [COORD_BITS-1:0]         plane_offset_i,
  input  logic signed [COORD_BITS-1:0]         box_min_x_i,
  input  logic signed [COORD_BITS-1:0]         box_min_y_i,
  input  logic signed [COORD_BITS-1:0]         box_min_z_i,
  input  logic signed [COORD_BITS-1:0]         box_max_x_i,
  input  logic signed [COORD_BITS-1:0]         box_max_y_i,
  input  logic signed [COORD_BITS-1:0]         box_max_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           action_o,
  output logic                                 range_error_o
);
  localparam int unsigned Depth = 4;

  logic signed [COORD_BITS-1:0]         cam_q [3];
  logic [2:0]                           count_q;
  logic signed [pbfc_pkg::NormBits-1:0] norm_q [MAX_PLANES][3];
  logic signed [COORD_BITS-1:0]         offs_q [MAX_PLANES];

  logic signed [COORD_BITS-1:0] lo_in [3], hi_in [3];
  logic signed [COORD_BITS-1:0] lo_q [3], hi_q [3];
  pbfc_pkg::verdict_t           vin, v_q [Depth];
  logic [Depth-1:0]             valid_q;
  logic [MAX_PLANES-1:0]        act_q [Depth];
  logic [MAX_PLANES-1:0]        rej;
  logic                         en, in_acc;

  assign lo_in = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi_in = '{box_max_x_i, box_max_y_i, box_max_z_i};

  assign en         = !valid_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q   <= '{default: '0};
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pbfc_pkg::CfgCamX:       cam_q[0] <= cfg_data_i;
        pbfc_pkg::CfgCamY:       cam_q[1] <= cfg_data_i;
        pbfc_pkg::CfgCamZ:       cam_q[2] <= cfg_data_i;
        pbfc_pkg::CfgPlaneCount: count_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_i == pbfc_pkg::CmdLoad && 32'(plane_slot_i) < MAX_PLANES) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
        if (32'(plane_slot_i) == p) begin
          norm_q[p] <= '{normal_x_i, normal_y_i, normal_z_i};
          offs_q[p] <= plane_offset_i;
        end
      end
    end
  end

  pbfc_box_check #(.COORD_BITS(COORD_BITS)) u_box (
    .lo_i(lo_in), .hi_i(hi_in), .cam_i(cam_q), .verdict_o(vin)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], in_acc && cmd_i == pbfc_pkg::CmdClassify};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q <= lo_in;
      hi_q <= hi_in;
      v_q[0] <= vin;
      for (int s = 1; s < Depth; s++) v_q[s] <= v_q[s-1];
      for (int p = 0; p < MAX_PLANES; p++) act_q[0][p] <= (32'(count_q) > p);
      for (int s = 1; s < Depth; s++) act_q[s] <= act_q[s-1];
    end
  end

  for (genvar p = 0; p < MAX_PLANES; p++) begin : g_lane
    pbfc_plane_dot #(.COORD_BITS(COORD_BITS)) u_dot (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .lo_i(lo_q), .hi_i(hi_q), .normal_i(norm_q[p]), .offset_i(offs_q[p]),
      .reject_o(rej[p])
    );
  end

  assign out_valid_o   = valid_q[Depth-1];
  assign range_error_o = v_q[Depth-1].range_error;
  assign action_o = v_q[Depth-1].decided ? v_q[Depth-1].action :
                    (|(rej & act_q[Depth-1])) ? pbfc_pkg::ActReject : pbfc_pkg::ActProject;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o))
    else $error("result changed under stall");
  a_err_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> action_o == pbfc_pkg::ActFull)
    else $error("range error with non-full action");
  a_load_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i == pbfc_pkg::CmdLoad |=> !valid_q[0])
    else $error("load produced a result");
`endif
endmodule

>>> tb/sv/tb_top.sv
// Testbench for portal_box_frustum_classify: plane loads and box classify requests,
// checked against an in-bench fixed-point predictor. Depends on pbfc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NPL = 6;
  localparam int unsigned CB = 24;

  typedef struct packed {
    logic    cmd;
    logic [2:0] slot;
    logic signed [15:0] nx, ny, nz;
    logic signed [CB-1:0] ofs;
    logic signed [CB-1:0] mnx, mny, mnz, mxx, mxy, mxz;
  } request_t;

  typedef struct packed {
    pbfc_pkg::action_e act;
    logic    rerr;
  } verdict_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CB-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  request_t req_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] action_o;
  logic range_error_o;

  portal_box_frustum_classify u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(req_q.cmd), .plane_slot_i(req_q.slot),
    .normal_x_i(req_q.nx), .normal_y_i(req_q.ny), .normal_z_i(req_q.nz),
    .plane_offset_i(req_q.ofs),
    .box_min_x_i(req_q.mnx), .box_min_y_i(req_q.mny), .box_min_z_i(req_q.mnz),
    .box_max_x_i(req_q.mxx), .box_max_y_i(req_q.mxy), .box_max_z_i(req_q.mxz),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .action_o(action_o), .range_error_o(range_error_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  longint cam_pos[3];
  int unsigned active_planes;
  longint pl_norm[NPL][3];
  longint pl_ofs[NPL];
  verdict_exp_t verdicts_due[$];
  int errors = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;

  function automatic verdict_exp_t classify_box(request_t r);
    longint lo[3], hi[3], s, p;
    int n;
    bit cam_in;
    verdict_exp_t v;
    lo[0] = longint'(r.mnx); lo[1] = longint'(r.mny); lo[2] = longint'(r.mnz);
    hi[0] = longint'(r.mxx); hi[1] = longint'(r.mxy); hi[2] = longint'(r.mxz);
    v.rerr = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (lo[i] > hi[i]) begin
        v.act = pbfc_pkg::ActFull;
        v.rerr = 1'b1;
        return v;
      end
    end
    cam_in = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (cam_pos[i] < lo[i] - 256 || cam_pos[i] > hi[i] + 256) cam_in = 1'b0;
    end
    if (cam_in) begin
      v.act = pbfc_pkg::ActFull;
      return v;
    end
    n = (active_planes > NPL) ? int'(NPL) : int'(active_planes);
    for (int i = 0; i < n; i++) begin
      s = pl_ofs[i] * 16384;
      for (int j = 0; j < 3; j++) begin
        p = (pl_norm[i][j] > 0) ? lo[j] : hi[j];
        s += p * pl_norm[i][j];
      end
      if (s > 0) begin
        v.act = pbfc_pkg::ActReject;
        return v;
      end
    end
    v.act = pbfc_pkg::ActProject;
    return v;
  endfunction

  task automatic write_reg(pbfc_pkg::cfg_idx_e idx, logic [CB-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pbfc_pkg::CfgCamX: cam_pos[0] = longint'($signed(val));
      pbfc_pkg::CfgCamY: cam_pos[1] = longint'($signed(val));
      pbfc_pkg::CfgCamZ: cam_pos[2] = longint'($signed(val));
      default: active_planes = val[2:0];
    endcase
  endtask

  // Sender: called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_request(request_t r);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_q <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.cmd == pbfc_pkg::CmdLoad) begin
      if (r.slot < NPL) begin
        pl_norm[r.slot][0] = longint'(r.nx);
        pl_norm[r.slot][1] = longint'(r.ny);
        pl_norm[r.slot][2] = longint'(r.nz);
        pl_ofs[r.slot] = longint'(r.ofs);
      end
    end else begin
      verdicts_due.push_back(classify_box(r));
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return CB'($signed(CB'($urandom_range(0, 4096))) - 2048);
      2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
      default: return CB'($signed(CB'($urandom_range(0, 65535))) - 32768);
    endcase
  endfunction

  function automatic request_t rand_plane(int unsigned slot);
    request_t r;
    r = '0;
    r.cmd = pbfc_pkg::CmdLoad;
    r.slot = 3'(slot);
    r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    if ($urandom_range(0, 3) == 0) r.nx = 16'sh4000;
    r.ofs = rand_coord();
    return r;
  endfunction

  function automatic request_t rand_box();
    request_t r;
    logic signed [CB-1:0] a, b;
    r = '0;
    r.cmd = pbfc_pkg::CmdClassify;
    r.slot = 3'($urandom);
    r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    r.ofs = CB'($urandom);
    for (int i = 0; i < 3; i++) begin
      a = rand_coord();
      b = rand_coord();
      if ($urandom_range(0, 15) != 0 && a > b) begin
        logic signed [CB-1:0] t;
        t = a; a = b; b = t;
      end
      case (i)
        0: begin r.mnx = a; r.mxx = b; end
        1: begin r.mny = a; r.mxy = b; end
        default: begin r.mnz = a; r.mxz = b; end
      endcase
    end
    return r;
  endfunction

  function automatic request_t box_of(longint lx, ly, lz, hx, hy, hz);
    request_t r;
    r = '0;
    r.cmd = pbfc_pkg::CmdClassify;
    r.mnx = CB'(lx); r.mny = CB'(ly); r.mnz = CB'(lz);
    r.mxx = CB'(hx); r.mxy = CB'(hy); r.mxz = CB'(hz);
    return r;
  endfunction

  task automatic load_all_planes();
    for (int s = 0; s < NPL; s++) send_request(rand_plane(s));
  endtask

  task automatic test_directed();
    request_t r;
    write_reg(pbfc_pkg::CfgPlaneCount, 24'd0);
    send_request(box_of(0, 0, 0, 10, 10, 10));
    send_request(box_of(256, -256, 0, 512, 0, 0));
    send_request(box_of(257, 0, 0, 512, 0, 0));
    send_request(box_of(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_request(box_of(5, 0, 0, 4, 0, 0));
    send_request(box_of(0, 0, 9, 100, 100, 8));
    r = rand_plane(6); send_request(r);
    r = rand_plane(7); send_request(r);
    r = '0; r.cmd = pbfc_pkg::CmdLoad; r.slot = 3'd0; r.nx = 16'sh7fff; r.ny = 16'sh8000;
    r.nz = 16'sh0000; r.ofs = 24'sh7fffff;
    send_request(r);
    r.slot = 3'd1; r.nx = 16'sh8000; r.ny = 16'sh7fff; r.nz = 16'sh4000;
    r.ofs = 24'sh800000;
    send_request(r);
    for (int s = 2; s < NPL; s++) send_request(rand_plane(s));
    drain();
    write_reg(pbfc_pkg::CfgPlaneCount, 24'd7);
    write_reg(pbfc_pkg::CfgCamX, 24'h7fffff);
    write_reg(pbfc_pkg::CfgCamY, 24'h800000);
    write_reg(pbfc_pkg::CfgCamZ, 24'h000100);
    send_request(box_of(1000, 1000, 1000, 2000, 2000, 2000));
    send_request(box_of(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_request(box_of(-100, -100, -100, -100, -100, -100));
    send_request(box_of(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    drain();
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pbfc_pkg::CfgPlaneCount, CB'($urandom_range(0, 7)));
      write_reg(pbfc_pkg::CfgCamX, rand_coord());
      write_reg(pbfc_pkg::CfgCamY, rand_coord());
      write_reg(pbfc_pkg::CfgCamZ, rand_coord());
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 9) == 0) send_request(rand_plane($urandom_range(0, 7)));
        else send_request(rand_box());
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int k = 0; k < 60; k++) send_request(rand_box());
    drain();
    for (int k = 0; k < 20; k++) send_request(rand_box());
    drain();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    write_reg(pbfc_pkg::CfgPlaneCount, 24'd6);
    write_reg(pbfc_pkg::CfgCamX, 24'h000000);
    for (int k = 0; k < 200; k++) send_request(rand_box());
  endtask

  initial begin
    active_planes = 0;
    for (int i = 0; i < 3; i++) cam_pos[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_configs();
    test_backpressure();
    test_no_idle();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    verdict_exp_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result action=%0d range_error=%0b",
                   $time, action_o, range_error_o);
          errors++;
        end else begin
          e = verdicts_due.pop_front();
          if (action_o !== e.act) begin
            $display("%0t: action expected %0d actual %0d", $time, e.act, action_o);
            errors++;
          end
          if (range_error_o !== e.rerr) begin
            $display("%0t: range_error expected %0b actual %0b", $time, e.rerr,
                     range_error_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
rtl/pbfc_pkg.sv
rtl/pbfc_plane_dot.sv
rtl/pbfc_box_check.sv
rtl/portal_box_frustum_classify.sv
tb/sv/tb_top.sv
